>>> hdl/dix_pkg.sv
package dix_pkg;

	// Bytes in the longest encoding: prefix, escape, flag byte, three magnitude bytes
	localparam int unsigned JobBytes   = 6;
	localparam int unsigned LenW       = 3;
	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0]  DoneByte     = 8'h00;
	localparam logic [7:0]  NegPrefix    = 8'hff;
	localparam logic [7:0]  EscByte      = 8'hfe;
	localparam logic [7:0]  LongFlag     = 8'h80;
	localparam logic [31:0] ShortLimit   = 32'h0000_00fe;
	localparam logic [31:0] MidLimit     = 32'h0000_7fff;
	localparam logic [31:0] DoneIndex    = 32'hffff_ffff;
	localparam logic [31:0] LastPosReset = 32'hffff_ffff;
	localparam logic [31:0] LastNegReset = 32'h0000_0001;

	// One encoded index: bytes in send order, len counts valid bytes (1..6)
	typedef struct packed {
		logic [JobBytes-1:0][7:0] data;
		logic [LenW-1:0]          len;
	} dix_job_t;

endpackage

>>> hdl/dix_front.sv
module dix_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [31:0]         index_value,
	output dix_pkg::dix_job_t   job
);

	logic [31:0] last_pos_q;
	logic [31:0] last_neg_q;

	logic              is_done;
	logic              is_neg;
	logic [31:0]       mag;
	logic [31:0]       diff;
	logic              diff_short;
	logic              diff_long;
	logic [7:0]        tail [dix_pkg::JobBytes];
	logic [dix_pkg::LenW-1:0] tail_len;

	assign is_done = (index_value == dix_pkg::DoneIndex);
	assign is_neg  = index_value[31];
	assign mag     = is_neg ? (32'd0 - index_value) : index_value;
	assign diff    = mag - (is_neg ? last_neg_q : last_pos_q);

	assign diff_short = !diff[31] && (diff != 32'd0) && (diff < dix_pkg::ShortLimit);
	assign diff_long  = diff[31] || (diff > dix_pkg::MidLimit);

	always_comb begin
		for (int i = 0; i < dix_pkg::JobBytes; i++) begin
			tail[i] = dix_pkg::DoneByte;
		end
		if (diff_short) begin
			tail[0]  = diff[7:0];
			tail_len = dix_pkg::LenW'(1);
		end else if (diff_long) begin
			tail[0]  = dix_pkg::EscByte;
			tail[1]  = mag[31:24] | dix_pkg::LongFlag;
			tail[2]  = mag[7:0];
			tail[3]  = mag[15:8];
			tail[4]  = mag[23:16];
			tail_len = dix_pkg::LenW'(5);
		end else begin
			tail[0]  = dix_pkg::EscByte;
			tail[1]  = diff[15:8];
			tail[2]  = diff[7:0];
			tail_len = dix_pkg::LenW'(3);
		end
	end

	always_comb begin
		job = '0;
		if (is_done) begin
			job.data[0] = dix_pkg::DoneByte;
			job.len     = dix_pkg::LenW'(1);
		end else if (is_neg) begin
			job.data[0] = dix_pkg::NegPrefix;
			for (int i = 1; i < dix_pkg::JobBytes; i++) begin
				job.data[i] = tail[i-1];
			end
			job.len = tail_len + dix_pkg::LenW'(1);
		end else begin
			for (int i = 0; i < dix_pkg::JobBytes; i++) begin
				job.data[i] = tail[i];
			end
			job.len = tail_len;
		end
	end

	// Done marker leaves both references alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= dix_pkg::LastPosReset;
			last_neg_q <= dix_pkg::LastNegReset;
		end else if (accept && !is_done) begin
			if (is_neg) begin
				last_neg_q <= mag;
			end else begin
				last_pos_q <= mag;
			end
		end
	end

endmodule

>>> hdl/dix_queue.sv
module dix_queue #(
	parameter int unsigned Depth = dix_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  dix_pkg::dix_job_t wr_job,
	output logic              full,
	input  logic              rd_en,
	output dix_pkg::dix_job_t rd_job,
	output logic              head_valid
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	dix_pkg::dix_job_t mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   cnt_q;

	assign full       = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	a_ptrs_meet: assert property (@(posedge clk) disable iff (!arst_n)
		((cnt_q == '0) || (cnt_q == CntW'(Depth))) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with occupancy");

	a_head_len: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ((rd_job.len != '0) && (rd_job.len <= dix_pkg::LenW'(dix_pkg::JobBytes))))
		else $error("queued job has a bad byte count");

endmodule

>>> hdl/dix_back.sv
module dix_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dix_pkg::dix_job_t head,
	input  logic              head_valid,
	output logic              deq,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              last_byte
);

	logic [dix_pkg::LenW-1:0] ptr_q;
	logic                     out_valid_q;
	logic [7:0]               out_byte_q;
	logic                     last_byte_q;
	logic                     load;
	logic                     at_last;

	assign load    = head_valid && (!out_valid_q || pop);
	assign at_last = (ptr_q == head.len - dix_pkg::LenW'(1));
	assign deq     = load && at_last;

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_byte_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= head.data[ptr_q];
			last_byte_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				ptr_q       <= at_last ? '0 : ptr_q + dix_pkg::LenW'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_ptr_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (ptr_q < head.len))
		else $error("byte pointer beyond head job");

	a_mid_job_head: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q != '0) |-> head_valid)
		else $error("head job vanished mid-transfer");

endmodule

>>> hdl/delta_index_encoder_core.sv
// First byte of an index reaches out_byte through the job queue and then the output register.
// Throughput: one output byte per cycle while pop is held and jobs are queued; an index is 1 to 6 bytes,
//   sent one at a time through the single-byte output register in the serializer.
// Input accepts every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset (arst_n low, async): queue and output empty, last positive index = -1,
//   last negative magnitude = 1.
module delta_index_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = dix_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] index_value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	// Front: classifies the index (done marker, positive, negative), takes the
	// difference against the matching reference and builds the byte list.
	// References update at the input transfer, so back-to-back indices chain.
	dix_pkg::dix_job_t front_job;
	dix_pkg::dix_job_t head_job;
	logic              accept;
	logic              head_valid;
	logic              deq;

	assign accept = push && !full;

	dix_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.index_value (index_value),
		.job         (front_job)
	);

	// Job queue decouples classification from the byte-serial back end.
	dix_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept),
		.wr_job     (front_job),
		.full       (full),
		.rd_en      (deq),
		.rd_job     (head_job),
		.head_valid (head_valid)
	);

	// Back: walks the head job one byte per transfer, flags the final byte,
	// and holds the current byte in an output register until popped.
	dix_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.head_valid (head_valid),
		.deq        (deq),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule

>>> tb/sv/dix_stream_checker.sv
module dix_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [31:0] index_value,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  out_byte,
	input  logic        last_byte,
	output int          error_count,
	output int          bytes_pending,
	output int          indices_seen,
	output int          bytes_seen
);

	typedef struct {
		logic [7:0] value;
		logic       last;
	} enc_byte_t;

	enc_byte_t   encoded_q[$];
	logic [31:0] prev_pos;
	logic [31:0] prev_neg_mag;

	// Appends the byte sequence for one index and advances the delta state
	task automatic encode_index(input logic [31:0] idx);
		logic [7:0] seq[dix_pkg::JobBytes];
		int         n;
		logic [31:0] mag;
		logic [31:0] diff;
		enc_byte_t  entry;
		n = 0;
		if (idx == dix_pkg::DoneIndex) begin
			seq[0] = dix_pkg::DoneByte;
			n = 1;
		end else begin
			if (!idx[31]) begin
				mag = idx;
				diff = mag - prev_pos;
				prev_pos = mag;
			end else begin
				seq[n] = dix_pkg::NegPrefix;
				n++;
				mag = -idx;
				diff = mag - prev_neg_mag;
				prev_neg_mag = mag;
			end
			if (!diff[31] && diff != 0 && diff < dix_pkg::ShortLimit) begin
				seq[n] = diff[7:0];
				n++;
			end else if (diff[31] || diff > dix_pkg::MidLimit) begin
				seq[n]   = dix_pkg::EscByte;
				seq[n+1] = mag[31:24] | dix_pkg::LongFlag;
				seq[n+2] = mag[7:0];
				seq[n+3] = mag[15:8];
				seq[n+4] = mag[23:16];
				n += 5;
			end else begin
				seq[n]   = dix_pkg::EscByte;
				seq[n+1] = diff[15:8];
				seq[n+2] = diff[7:0];
				n += 3;
			end
		end
		for (int i = 0; i < n; i++) begin
			entry.value = seq[i];
			entry.last  = (i == n - 1);
			encoded_q.insert(encoded_q.size(), entry);
		end
	endtask

	// Compare before predicting, so a byte can never match an index pushed on the same edge
	always @(posedge clk or negedge arst_n) begin
		enc_byte_t want;
		if (!arst_n) begin
			encoded_q.delete();
			prev_pos     = dix_pkg::LastPosReset;
			prev_neg_mag = dix_pkg::LastNegReset;
			error_count  = 0;
			indices_seen = 0;
			bytes_seen   = 0;
		end else begin
			if (pop && !empty) begin
				bytes_seen++;
				if (encoded_q.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: unexpected byte %02h last=%0b", $realtime, out_byte,
							last_byte);
				end else begin
					want = encoded_q.pop_front();
					if (out_byte !== want.value || last_byte !== want.last) begin
						error_count++;
						if (error_count <= 10)
							$display("%0t: byte mismatch exp %02h/%0b got %02h/%0b", $realtime,
								want.value, want.last, out_byte, last_byte);
					end
				end
			end
			if (push && !full) begin
				indices_seen++;
				encode_index(index_value);
			end
		end
		bytes_pending = encoded_q.size();
	end

endmodule

>>> tb/sv/delta_index_encoder_core_tb.sv
module delta_index_encoder_core_tb;

	localparam int CycleLimit    = 200000;
	localparam int HoldOffCycles = 60;
	localparam int RandomIndices = 380;
	localparam int DrainCycles   = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] index_value = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        last_byte;

	int error_count;
	int bytes_pending;
	int indices_seen;
	int bytes_seen;
	int cycle_count = 0;
	int hold_offs = 0;

	// Sender/receiver pacing knobs, set by the stimulus process
	bit tx_burst = 1'b0;
	bit hold_off_req = 1'b0;

	// Stimulus-side view of the last indices sent, used only to stay near them
	logic [31:0] sent_pos = '0;
	logic [31:0] sent_neg_mag = 32'd1;

	always #5 clk = ~clk;

	delta_index_encoder_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.index_value (index_value),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

	dix_stream_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.index_value   (index_value),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.last_byte     (last_byte),
		.error_count   (error_count),
		.bytes_pending (bytes_pending),
		.indices_seen  (indices_seen),
		.bytes_seen    (bytes_seen)
	);

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("[delta_index_encoder_core] ERROR");
			$finish;
		end
	end

	// Offer one index: optional idle gap, then hold push until a transfer.
	// push is only lowered when a gap is taken, so back-to-back items keep it high.
	task automatic offer_index(input logic [31:0] v);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		index_value <= v;
		do @(posedge clk); while (full);
	endtask

	// Next value near a base: mostly short and mid deltas, some repeats, long jumps and
	// backward steps; falls back to a small value when the step leaves 0..2^31-1
	function automatic logic [31:0] near_value(input logic [31:0] base);
		longint nxt;
		int     pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			nxt = longint'(base) + $urandom_range(1, 253);
		else if (pick < 70)
			nxt = longint'(base) + $urandom_range(254, 32767);
		else if (pick < 80)
			nxt = longint'(base);
		else if (pick < 90)
			nxt = longint'(base) + $urandom_range(32768, 1 << 24);
		else
			nxt = longint'(base) - $urandom_range(1, 40000);
		if (nxt < 0 || nxt > 64'h7fff_ffff)
			nxt = $urandom_range(0, 5000);
		return nxt[31:0];
	endfunction

	// Receiver: random stall per byte, burst stretches with no stall, and a long
	// hold-off on request so the job queue fills and full backs up the sender
	initial begin
		int stall;
		bit rx_burst;
		rx_burst = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_burst = ~rx_burst;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_offs++;
				stall = HoldOffCycles;
			end else begin
				stall = rx_burst ? 0 : $urandom_range(0, 4);
			end
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		int          directed[$];
		logic [31:0] v;
		logic [31:0] mag;
		int          pick;
		int          burst_left;

		// Delta boundaries from the reset state: done marker, delta 1, 0, 253, 254,
		// 32767, 32768, backward and huge steps; negative side: 1, 0, 253, 254, 32767,
		// huge and backward steps, including the most negative index whose magnitude wraps to 2^31
		directed = '{-1, 0, 0, 253, 507, 33274, 66042, 0, 2147483647, 2147483646,
			-2, -2, -255, -509, -33276, -2147483647, 32'sh8000_0000, -3, -1, 1, 32'h7fff};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			offer_index(directed[i]);

		burst_left = 0;
		for (int i = 0; i < RandomIndices; i++) begin
			// Two forced back-pressure episodes with the sender running flat out
			if (i == 100 || i == 250) begin
				hold_off_req = 1'b1;
				burst_left = 24;
			end
			if (i % 40 == 0)
				tx_burst = ($urandom_range(0, 3) == 0);
			if (burst_left > 0) begin
				tx_burst = 1'b1;
				burst_left--;
				if (burst_left == 0)
					tx_burst = 1'b0;
			end

			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				sent_pos = near_value(sent_pos);
				v = sent_pos;
			end else if (pick < 72) begin
				// magnitude 1 would be the done marker, keep it off the negative path
				mag = near_value(sent_neg_mag);
				if (mag < 2)
					mag = mag + 2;
				sent_neg_mag = mag;
				v = -mag;
			end else if (pick < 80) begin
				v = 32'hffff_ffff;
			end else begin
				v = $urandom;
			end
			offer_index(v);
		end

		@(negedge clk);
		push <= 1'b0;
		tx_burst = 1'b0;

		// Checker has sampled the last transfer by this edge; drain, then let stray bytes show
		wait (bytes_pending == 0);
		repeat (DrainCycles) @(posedge clk);

		$display("Encoded %0d indices into %0d checked bytes, %0d receiver hold-offs.",
			indices_seen, bytes_seen, hold_offs);
		if (error_count == 0)
			$display("[delta_index_encoder_core] OK");
		else
			$display("[delta_index_encoder_core] ERROR");
		$finish;
	end

endmodule
